### rtl/core/ustar_archive_stream_reader_macros.svh
// Assertion macros shared by the ustar archive stream reader RTL.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef USTAR_ARCHIVE_STREAM_READER_MACROS_SVH
`define USTAR_ARCHIVE_STREAM_READER_MACROS_SVH

// Checked on every clock edge outside reset.
`define UASR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define UASR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/uasr_pkg.sv
// Shared types and constants of the ustar archive stream reader.
// No dependencies.
`default_nettype none
package uasr_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int NAME_BYTES  = 100;
  localparam int LEN_W       = 40;
  localparam int OCT_W       = 34;
  localparam int NAME_ROWS   = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [8:0] OFF_SIZE_FIRST = 9'd124;
  localparam logic [8:0] OFF_SIZE_LAST  = 9'd134;
  localparam logic [8:0] OFF_SIZE_END   = 9'd135;
  localparam logic [8:0] OFF_TYPE       = 9'd156;
  localparam logic [8:0] OFF_MAGIC      = 9'd257;
  localparam logic [8:0] OFF_MAGIC_LAST = 9'd261;
  localparam logic [8:0] OFF_VER0       = 9'd263;
  localparam logic [8:0] OFF_VER1       = 9'd264;
  localparam logic [8:0] OFF_LAST       = 9'd511;
  localparam logic [LEN_W-1:0] MIN_ARCHIVE = 40'd1024;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [2:0] ERR_TOO_SMALL   = 3'd0;
  localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd4;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NAMES = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_OK    = 2'd2,
    CMD_ERR   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] fsize;
    logic             then_ok;
    logic [2:0]       err;
  } cmd_t;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [7:0] data;
  } name_wr_t;

  typedef struct packed {
    logic names_done;
  } back_status_t;

  function automatic logic [7:0] magic_char(input logic [8:0] off);
    logic [7:0] c;
    case (off)
      9'd257:  c = 8'h75;
      9'd258:  c = 8'h73;
      9'd259:  c = 8'h74;
      9'd260:  c = 8'h61;
      9'd261:  c = 8'h72;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/uasr_front.sv
// Front end: takes archive bytes, tracks header, data and padding, and queues commands.
// Depends on uasr_pkg.
`default_nettype none
module uasr_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [uasr_pkg::LEN_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         q_full,
  output logic                              push,
  output uasr_pkg::cmd_t                    cmd,
  output uasr_pkg::name_wr_t                name_wr,
  input  wire uasr_pkg::back_status_t       back_status
);

  uasr_pkg::phase_t phase, phase_next;
  logic [8:0]                   bo, bo_next;
  logic [uasr_pkg::LEN_W-1:0]   pos, pos_next, rem, rem_next, dec, dec_next, length;
  logic [uasr_pkg::OCT_W-1:0]   oct, oct_next;
  logic oct_mode, oct_mode_next, dig_ok, dig_ok_next, oct_stop, oct_stop_next;
  logic magic_ok, magic_ok_next, ver_ok, ver_ok_next, reg_file, reg_file_next;
  logic names_wait;

  logic                         acc, too_small, digit, hdr_endc, data_endc;
  logic [3:0]                   d;
  logic [uasr_pkg::LEN_W-1:0]   fs;
  logic [31:0]                  np_blk;

  assign in_ready  = !q_full && !(names_wait && phase == uasr_pkg::PH_HEADER && bo < 9'd100);
  assign acc       = in_valid && in_ready;
  assign too_small = phase == uasr_pkg::PH_HEADER && bo == 9'd0 && pos == '0 &&
                     length < uasr_pkg::MIN_ARCHIVE;
  assign digit     = in_byte >= 8'h30 && in_byte <= 8'h39;
  assign d         = digit ? 4'(in_byte - 8'h30) : in_byte[3:0];
  assign fs        = oct_mode ? uasr_pkg::LEN_W'(oct) : dec;
  assign hdr_endc  = ({1'b0, pos_next} + 41'd512) > {1'b0, length};
  assign np_blk    = {1'b0, pos_next[39:9]} + {31'd0, (pos_next[8:0] != 9'd0)};
  assign data_endc = {np_blk + 32'd1, 9'd0} > {1'b0, length};

  assign name_wr.en   = acc && phase == uasr_pkg::PH_HEADER && !too_small && bo < 9'd100;
  assign name_wr.addr = bo[6:0];
  assign name_wr.data = in_byte;

  always_comb begin
    phase_next    = phase;
    bo_next       = bo;
    pos_next      = pos;
    rem_next      = rem;
    dec_next      = dec;
    oct_next      = oct;
    oct_mode_next = oct_mode;
    dig_ok_next   = dig_ok;
    oct_stop_next = oct_stop;
    magic_ok_next = magic_ok;
    ver_ok_next   = ver_ok;
    reg_file_next = reg_file;
    push          = 1'b0;
    cmd           = '0;
    if (acc && phase != uasr_pkg::PH_DONE) begin
      if (too_small) begin
        push       = 1'b1;
        cmd.kind   = uasr_pkg::CMD_ERR;
        cmd.err    = uasr_pkg::ERR_TOO_SMALL;
        phase_next = uasr_pkg::PH_DONE;
      end else begin
        bo_next  = bo + 9'd1;
        pos_next = pos + 40'd1;
        case (phase)
          uasr_pkg::PH_HEADER: begin
            if (bo == 9'd0) begin
              dec_next      = '0;
              oct_next      = '0;
              oct_mode_next = 1'b0;
              dig_ok_next   = 1'b1;
              oct_stop_next = 1'b0;
              magic_ok_next = 1'b1;
              ver_ok_next   = 1'b1;
              reg_file_next = 1'b0;
            end
            if (bo inside {[uasr_pkg::OFF_SIZE_FIRST:uasr_pkg::OFF_SIZE_LAST]}) begin
              if (!digit) begin
                dig_ok_next = 1'b0;
              end else begin
                dec_next = (dec << 3) + (dec << 1) + {36'd0, d};
                if (!oct_stop) begin
                  if (d <= 4'd7) oct_next = {oct[30:0], d[2:0]};
                  else oct_stop_next = 1'b1;
                end
              end
            end else if (bo == uasr_pkg::OFF_SIZE_END) begin
              if (in_byte == 8'h00) oct_mode_next = 1'b1;
              else if (digit) dec_next = (dec << 3) + (dec << 1) + {36'd0, d};
              else dig_ok_next = 1'b0;
            end else if (bo == uasr_pkg::OFF_TYPE) begin
              reg_file_next = in_byte == 8'h30;
            end else if (bo inside {[uasr_pkg::OFF_MAGIC:uasr_pkg::OFF_MAGIC_LAST]}) begin
              if (in_byte != uasr_pkg::magic_char(bo)) magic_ok_next = 1'b0;
            end else if (bo == uasr_pkg::OFF_VER0 || bo == uasr_pkg::OFF_VER1) begin
              if (in_byte != 8'h30) ver_ok_next = 1'b0;
            end
            if (bo == uasr_pkg::OFF_LAST) begin
              phase_next = uasr_pkg::PH_DONE;
              if (!dig_ok) begin
                push     = 1'b1;
                cmd.kind = uasr_pkg::CMD_OK;
              end else if (oct_mode && oct[33:31] != 3'd0) begin
                push     = 1'b1;
                cmd.kind = uasr_pkg::CMD_ERR;
                cmd.err  = uasr_pkg::ERR_OVERFLOW;
              end else if (!magic_ok) begin
                push     = 1'b1;
                cmd.kind = uasr_pkg::CMD_ERR;
                cmd.err  = uasr_pkg::ERR_BAD_MAGIC;
              end else if (!ver_ok) begin
                push     = 1'b1;
                cmd.kind = uasr_pkg::CMD_ERR;
                cmd.err  = uasr_pkg::ERR_BAD_VERSION;
              end else if (({1'b0, fs} + {1'b0, pos_next}) > {1'b0, length}) begin
                push     = 1'b1;
                cmd.kind = uasr_pkg::CMD_ERR;
                cmd.err  = uasr_pkg::ERR_TRUNCATED;
              end else if (fs == '0) begin
                phase_next = hdr_endc ? uasr_pkg::PH_DONE : uasr_pkg::PH_HEADER;
                if (reg_file) begin
                  push        = 1'b1;
                  cmd.kind    = uasr_pkg::CMD_NAMES;
                  cmd.fsize   = fs;
                  cmd.then_ok = hdr_endc;
                end else if (hdr_endc) begin
                  push     = 1'b1;
                  cmd.kind = uasr_pkg::CMD_OK;
                end
              end else begin
                rem_next   = fs;
                phase_next = uasr_pkg::PH_DATA;
                if (reg_file) begin
                  push      = 1'b1;
                  cmd.kind  = uasr_pkg::CMD_NAMES;
                  cmd.fsize = fs;
                end
              end
            end
          end
          uasr_pkg::PH_DATA: begin
            rem_next = rem - 40'd1;
            if (rem_next == '0) begin
              if (data_endc) phase_next = uasr_pkg::PH_DONE;
              else if (bo_next == 9'd0) phase_next = uasr_pkg::PH_HEADER;
              else phase_next = uasr_pkg::PH_PAD;
            end
            if (reg_file) begin
              push        = 1'b1;
              cmd.kind    = uasr_pkg::CMD_DATA;
              cmd.data    = in_byte;
              cmd.then_ok = rem_next == '0 && data_endc;
            end else if (rem_next == '0 && data_endc) begin
              push     = 1'b1;
              cmd.kind = uasr_pkg::CMD_OK;
            end
          end
          uasr_pkg::PH_PAD: begin
            if (bo_next == 9'd0) phase_next = uasr_pkg::PH_HEADER;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= uasr_pkg::PH_HEADER;
      bo         <= '0;
      pos        <= '0;
      rem        <= '0;
      dec        <= '0;
      oct        <= '0;
      oct_mode   <= 1'b0;
      dig_ok     <= 1'b1;
      oct_stop   <= 1'b0;
      magic_ok   <= 1'b1;
      ver_ok     <= 1'b1;
      reg_file   <= 1'b0;
      names_wait <= 1'b0;
      length     <= '0;
    end else begin
      phase      <= phase_next;
      bo         <= bo_next;
      pos        <= pos_next;
      rem        <= rem_next;
      dec        <= dec_next;
      oct        <= oct_next;
      oct_mode   <= oct_mode_next;
      dig_ok     <= dig_ok_next;
      oct_stop   <= oct_stop_next;
      magic_ok   <= magic_ok_next;
      ver_ok     <= ver_ok_next;
      reg_file   <= reg_file_next;
      names_wait <= (names_wait && !back_status.names_done) ||
                    (push && cmd.kind == uasr_pkg::CMD_NAMES);
      if (cfg_we) length <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/uasr_queue.sv
// Four-entry command queue between the front end and the result sequencer.
// Depends on uasr_pkg.
`default_nettype none
module uasr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire uasr_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output logic                not_empty,
  output logic                full,
  output uasr_pkg::cmd_t      head_cmd
);

  uasr_pkg::cmd_t entries [uasr_pkg::QUEUE_DEPTH];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;

  assign not_empty = count != 3'd0;
  assign full      = count == 3'(uasr_pkg::QUEUE_DEPTH);
  assign head_cmd  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/core/uasr_back.sv
// Result sequencer: holds the name store and expands queued commands into result transfers.
// Depends on uasr_pkg and the assertion macros header.
`default_nettype none
`include "ustar_archive_stream_reader_macros.svh"
module uasr_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire uasr_pkg::name_wr_t          name_wr,
  input  wire logic                        q_not_empty,
  input  wire uasr_pkg::cmd_t              q_cmd,
  output logic                             pop,
  output uasr_pkg::back_status_t           status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_kind,
  output logic [63:0]                      out_payload,
  output logic [3:0]                       out_vbytes,
  output logic [uasr_pkg::LEN_W-1:0]       out_fsize,
  output logic [2:0]                       out_err,
  output logic                             out_last
);

  logic [63:0] store [uasr_pkg::NAME_ROWS];
  logic        nm_active, nm_ok, ok_pending, adv, last_chunk;
  logic [3:0]  nm_idx;
  logic [uasr_pkg::LEN_W-1:0] nm_fs;
  logic [63:0] row;

  assign adv        = !out_valid || out_ready;
  assign last_chunk = nm_idx == 4'(uasr_pkg::NAME_ROWS - 1);
  assign pop        = adv && !nm_active && !ok_pending && q_not_empty;
  assign status.names_done = adv && nm_active && last_chunk;
  assign row        = store[nm_idx];

  always_ff @(posedge clk) begin
    if (name_wr.en) store[name_wr.addr[6:3]][name_wr.addr[2:0]*8 +: 8] <= name_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      nm_active  <= 1'b0;
      ok_pending <= 1'b0;
    end else if (adv) begin
      out_valid   <= 1'b1;
      out_payload <= '0;
      out_vbytes  <= '0;
      out_fsize   <= '0;
      out_err     <= '0;
      out_last    <= 1'b1;
      if (nm_active) begin
        out_kind    <= uasr_pkg::KIND_NAME;
        out_payload <= last_chunk ? {32'd0, row[31:0]} : row;
        out_vbytes  <= last_chunk ? 4'd4 : 4'd8;
        out_fsize   <= nm_fs;
        out_last    <= last_chunk && !nm_ok;
        nm_idx      <= nm_idx + 4'd1;
        if (last_chunk) begin
          nm_active  <= 1'b0;
          ok_pending <= nm_ok;
        end
      end else if (ok_pending) begin
        out_kind   <= uasr_pkg::KIND_OK;
        ok_pending <= 1'b0;
      end else if (q_not_empty) begin
        case (q_cmd.kind)
          uasr_pkg::CMD_NAMES: begin
            out_kind    <= uasr_pkg::KIND_NAME;
            out_payload <= store[0];
            out_vbytes  <= 4'd8;
            out_fsize   <= q_cmd.fsize;
            out_last    <= 1'b0;
            nm_active   <= 1'b1;
            nm_idx      <= 4'd1;
            nm_fs       <= q_cmd.fsize;
            nm_ok       <= q_cmd.then_ok;
          end
          uasr_pkg::CMD_DATA: begin
            out_kind    <= uasr_pkg::KIND_DATA;
            out_payload <= {56'd0, q_cmd.data};
            out_vbytes  <= 4'd1;
            out_last    <= !q_cmd.then_ok;
            ok_pending  <= q_cmd.then_ok;
          end
          uasr_pkg::CMD_OK: begin
            out_kind <= uasr_pkg::KIND_OK;
          end
          default: begin
            out_kind <= uasr_pkg::KIND_ERR;
            out_err  <= q_cmd.err;
          end
        endcase
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  `UASR_ASSERT(a_no_overlap, !(nm_active && ok_pending), "name run and pending finish overlap")
  `UASR_ASSERT(a_idx_range, nm_active |-> nm_idx <= 4'(uasr_pkg::NAME_ROWS - 1), "chunk index out of range")
  `UASR_ASSERT(a_last_chunk, (status.names_done && !nm_ok) |=> (out_last && out_kind == uasr_pkg::KIND_NAME), "last name chunk not marked")
  `UASR_ASSERT_ALWAYS(a_pop_nonempty, pop |-> q_not_empty, "pop from empty queue")

endmodule
`default_nettype wire

### rtl/core/ustar_archive_stream_reader.sv
// ustar archive stream reader, top level: archive bytes in, name chunks, file data and status out.
// Input: s_tdata[7:0] is one archive byte per transfer. Output: m_tuser is the result kind
// (name chunk, data byte, finished, error); m_tlast marks the last result caused by one byte.
// cfg_we/cfg_wdata load the archive length before streaming starts.
// A byte is taken every cycle while s_tready is high. A data byte goes through the command queue
// and the output register; the last header byte of a regular file expands into 13 name chunks,
// sent one per cycle while m_tready is high. Until they are sent, the first 100 bytes of the next
// header are held off, since they overwrite the name store. Other bytes give at most one result
// each, plus a finish after the last data byte. A four-entry queue between parsing and the output
// register keeps the input flowing while the receiver stalls until it fills; then s_tready drops.
// After finish or error, bytes are taken and dropped until reset.
// Reset (rst, synchronous) clears the parser, queue and output; the length register reads 0.
// Depends on uasr_pkg, uasr_front, uasr_queue and uasr_back.
`default_nettype none
module ustar_archive_stream_reader (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [39:0]   cfg_wdata,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // data_byte
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [111:0]       m_tdata,   // payload, valid_bytes, file_size, error_code, zero pad
  output logic [1:0]         m_tuser,   // kind
  output logic               m_tlast
);

  uasr_pkg::cmd_t         cmd, head_cmd;
  uasr_pkg::name_wr_t     name_wr;
  uasr_pkg::back_status_t back_status;
  logic push, pop, q_not_empty, q_full;
  logic [63:0] payload;
  logic [3:0]  vbytes;
  logic [39:0] fsize;
  logic [2:0]  err;

  uasr_front u_front (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
    .q_full(q_full), .push(push), .cmd(cmd), .name_wr(name_wr),
    .back_status(back_status)
  );

  uasr_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(cmd), .pop(pop),
    .not_empty(q_not_empty), .full(q_full), .head_cmd(head_cmd)
  );

  uasr_back u_back (
    .clk(clk), .rst(rst), .name_wr(name_wr), .q_not_empty(q_not_empty),
    .q_cmd(head_cmd), .pop(pop), .status(back_status),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind(m_tuser),
    .out_payload(payload), .out_vbytes(vbytes), .out_fsize(fsize),
    .out_err(err), .out_last(m_tlast)
  );

  assign m_tdata = {1'b0, err, fsize, vbytes, payload};

endmodule
`default_nettype wire

### verif/ustar_archive_stream_reader_test.sv
// Self-checking testbench for ustar_archive_stream_reader: streams randomised ustar archives
// into the block and checks every output transfer against a built-in predictor.
// Depends on uasr_pkg and the RTL of ustar_archive_stream_reader.
`timescale 1ns / 100ps
`default_nettype none
module ustar_archive_stream_reader_test;
  import uasr_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] payload;
    logic [3:0]  valid_bytes;
    logic [39:0] file_size;
    logic [2:0]  error_code;
    logic        last;
  } tar_result_t;

  class tar_scoreboard;
    tar_result_t pending[$];
    int          failures;
    logic [39:0] alen;
    phase_t      phase;
    logic [8:0]  offset;
    logic [39:0] position;
    logic [63:0] remaining;
    logic [63:0] dec_size;
    logic [63:0] oct_size;
    bit          oct_mode, digits_ok, oct_stopped, magic_good, version_good, regular;
    logic [7:0]  names[NAME_BYTES];

    function new();
      failures = 0;
      alen = '0;
      phase = PH_HEADER;
      offset = '0;
      position = '0;
      remaining = '0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      failures++;
    endtask

    function void add(logic [1:0] k, logic [63:0] p, logic [3:0] vb, logic [39:0] fs,
                      logic [2:0] e);
      tar_result_t r;
      r.kind = k;
      r.payload = p;
      r.valid_bytes = vb;
      r.file_size = fs;
      r.error_code = e;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function bit beyond_end(logic [39:0] np);
      return np >= alen || (alen - np) < BLOCK_BYTES;
    endfunction

    function void header_done();
      logic [63:0] fs;
      logic [63:0] chunk;
      int          cnt;
      phase = PH_DONE;
      if (!digits_ok) begin
        add(KIND_OK, 0, 0, 0, 0);
        return;
      end
      if (oct_mode) begin
        if (oct_size > 64'd2147483647) begin
          add(KIND_ERR, 0, 0, 0, ERR_OVERFLOW);
          return;
        end
        fs = oct_size;
      end else begin
        fs = dec_size;
      end
      if (!magic_good) begin
        add(KIND_ERR, 0, 0, 0, ERR_BAD_MAGIC);
        return;
      end
      if (!version_good) begin
        add(KIND_ERR, 0, 0, 0, ERR_BAD_VERSION);
        return;
      end
      if (position > alen || fs > 64'(alen - position)) begin
        add(KIND_ERR, 0, 0, 0, ERR_TRUNCATED);
        return;
      end
      if (regular) begin
        for (int k = 0; k < NAME_ROWS; k++) begin
          chunk = '0;
          cnt = 0;
          for (int j = 0; j < 8; j++) begin
            if (k * 8 + j < NAME_BYTES) begin
              chunk[8*j +: 8] = names[k * 8 + j];
              cnt++;
            end
          end
          add(KIND_NAME, chunk, cnt, fs[39:0], 0);
        end
      end
      if (fs == 0) begin
        if (beyond_end(position)) add(KIND_OK, 0, 0, 0, 0);
        else phase = PH_HEADER;
      end else begin
        remaining = fs;
        phase = PH_DATA;
      end
    endfunction

    function void header_byte(logic [8:0] off, logic [7:0] b);
      bit         digit;
      logic [3:0] d;
      digit = (b >= "0" && b <= "9");
      d = digit ? 4'(b - "0") : b[3:0];
      if (off == 0) begin
        dec_size = 0;
        oct_size = 0;
        oct_mode = 0;
        digits_ok = 1;
        oct_stopped = 0;
        magic_good = 1;
        version_good = 1;
        regular = 0;
      end
      if (off < NAME_BYTES) names[off] = b;
      if (off >= OFF_SIZE_FIRST && off <= OFF_SIZE_LAST) begin
        if (!digit) begin
          digits_ok = 0;
        end else begin
          dec_size = dec_size * 10 + d;
          if (!oct_stopped) begin
            if (d <= 7) oct_size = oct_size * 8 + d;
            else oct_stopped = 1;
          end
        end
      end else if (off == OFF_SIZE_END) begin
        if (b == 0) oct_mode = 1;
        else if (digit) dec_size = dec_size * 10 + d;
        else digits_ok = 0;
      end else if (off == OFF_TYPE) begin
        regular = (b == "0");
      end else if (off >= OFF_MAGIC && off <= OFF_MAGIC_LAST) begin
        if (b != magic_char(off)) magic_good = 0;
      end else if (off == OFF_VER0 || off == OFF_VER1) begin
        if (b != "0") version_good = 0;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int         before_n;
      logic [8:0] off;
      logic [39:0] np;
      before_n = pending.size();
      if (phase == PH_DONE) return;
      if (phase == PH_HEADER && offset == 0 && position == 0 && alen < MIN_ARCHIVE) begin
        add(KIND_ERR, 0, 0, 0, ERR_TOO_SMALL);
        phase = PH_DONE;
      end else begin
        off = offset;
        offset = off + 1;
        position = position + 1;
        if (phase == PH_HEADER) begin
          header_byte(off, b);
          if (off == OFF_LAST) header_done();
        end else if (phase == PH_DATA) begin
          if (regular) add(KIND_DATA, {56'd0, b}, 1, 0, 0);
          remaining--;
          if (remaining == 0) begin
            np = position;
            if (offset != 0) np = np + (BLOCK_BYTES - offset);
            if (beyond_end(np)) begin
              add(KIND_OK, 0, 0, 0, 0);
              phase = PH_DONE;
            end else begin
              phase = (offset == 0) ? PH_HEADER : PH_PAD;
            end
          end
        end else if (offset == 0) begin
          phase = PH_HEADER;
        end
      end
      if (pending.size() > before_n) pending[$].last = 1'b1;
    endfunction

    task check_result(logic [1:0] kind, logic [111:0] tdata, logic last);
      tar_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result kind %0d", kind));
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind)
        report($sformatf("kind %0d, expected %0d", kind, e.kind));
      if (tdata[63:0] !== e.payload)
        report($sformatf("payload %h, expected %h", tdata[63:0], e.payload));
      if (tdata[67:64] !== e.valid_bytes)
        report($sformatf("valid bytes %0d, expected %0d", tdata[67:64], e.valid_bytes));
      if (tdata[107:68] !== e.file_size)
        report($sformatf("file size %0d, expected %0d", tdata[107:68], e.file_size));
      if (tdata[110:108] !== e.error_code)
        report($sformatf("error code %0d, expected %0d", tdata[110:108], e.error_code));
      if (last !== e.last)
        report($sformatf("last flag %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [39:0]   cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [111:0]  m_tdata;
  logic [1:0]    m_tuser;
  logic          m_tlast;

  tar_scoreboard sb = new();
  int            cyc = 0;
  int            hold_left = 0;

  ustar_archive_stream_reader i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  function automatic bit calm_window();
    return cyc >= 3000 && cyc < 3600;
  endfunction

  // The receiver holds off once for a long stretch so that the queue fills.
  always @(negedge clk) begin
    if (cyc == 1500) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm_window() || ($urandom_range(99) >= 36);
    end
  end

  task automatic write_length(logic [39:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.alen = v;
  endtask

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    while (!calm_window() && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Size field styles: octal, decimal, octal stopped by an 8 after a 1, octal starting with 8.
  localparam int SZ_OCT = 0, SZ_DEC = 1, SZ_OCT_STOP = 2, SZ_OCT_FIRST8 = 3;
  // Terminal entries.
  localparam int END_OK = 0, END_MAGIC = 1, END_VERSION = 2, END_TRUNC = 3,
                 END_OVERFLOW = 4, END_NONDIGIT = 5, END_TOO_SMALL = 6;

  task automatic send_header(logic [7:0] ftype, int style, logic [63:0] sz, int fault);
    logic [7:0] h[BLOCK_BYTES];
    logic [7:0] c;
    int         p;
    for (int i = 0; i < BLOCK_BYTES; i++) h[i] = 8'($urandom);
    case (style)
      SZ_DEC: begin
        for (int i = 0; i < 12; i++) h[135 - i] = 8'("0" + (sz / (64'd10 ** i)) % 10);
      end
      SZ_OCT_STOP: begin
        for (int i = 124; i <= 132; i++) h[i] = "0";
        h[133] = "1";
        h[134] = "8";
        h[135] = 8'h00;
      end
      SZ_OCT_FIRST8: begin
        h[124] = "8";
        for (int i = 125; i <= 134; i++) h[i] = 8'("0" + $urandom_range(9));
        h[135] = 8'h00;
      end
      default: begin
        for (int i = 0; i < 11; i++) h[134 - i] = 8'("0" + ((sz >> (3 * i)) & 7));
        h[135] = 8'h00;
      end
    endcase
    h[OFF_TYPE] = ftype;
    for (int i = OFF_MAGIC; i <= OFF_MAGIC_LAST; i++) h[i] = magic_char(i);
    h[OFF_VER0] = "0";
    h[OFF_VER1] = "0";
    if (fault == END_MAGIC) begin
      p = $urandom_range(OFF_MAGIC, OFF_MAGIC_LAST);
      do c = 8'($urandom); while (c == magic_char(p));
      h[p] = c;
    end else if (fault == END_VERSION) begin
      do c = 8'($urandom); while (c == "0");
      h[$urandom_range(0, 1) ? OFF_VER1 : OFF_VER0] = c;
    end else if (fault == END_NONDIGIT) begin
      p = $urandom_range(124, 135);
      do c = 8'($urandom); while ((c >= "0" && c <= "9") || (p == 135 && c == 0));
      h[p] = c;
    end
    for (int i = 0; i < BLOCK_BYTES; i++) send_byte(h[i]);
  endtask

  function automatic int padded(logic [63:0] sz);
    return int'((sz + BLOCK_BYTES - 1) / BLOCK_BYTES) * BLOCK_BYTES;
  endfunction

  initial begin
    int          entries;
    int          finish_kind;
    logic [7:0]  types[8];
    int          styles[8];
    logic [63:0] sizes[8];
    logic [39:0] total;
    logic [39:0] length;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    entries = $urandom_range(2, 5);
    total = 0;
    for (int e = 0; e < entries; e++) begin
      case ($urandom_range(9))
        0: types[e] = 8'h00;
        1: types[e] = "5";
        default: types[e] = "0";
      endcase
      styles[e] = $urandom_range(4) == 0 ? SZ_DEC : SZ_OCT;
      case ($urandom_range(5))
        0: sizes[e] = 0;
        1: sizes[e] = $urandom_range(500, 700);
        default: sizes[e] = $urandom_range(1, 40);
      endcase
      if (e == 1 && $urandom_range(1)) begin
        styles[e] = SZ_OCT_STOP;
        sizes[e] = 1;
      end
      if (e == 2 && $urandom_range(1)) begin
        styles[e] = SZ_OCT_FIRST8;
        sizes[e] = 0;
      end
      total += BLOCK_BYTES + padded(sizes[e]);
    end
    finish_kind = $urandom_range(END_TOO_SMALL);

    if (finish_kind == END_OK) length = total + $urandom_range(0, 511);
    else if (finish_kind == END_TOO_SMALL) length = $urandom_range(1, 1023);
    else length = total + BLOCK_BYTES + $urandom_range(0, 1500);

    write_length('0);
    write_length('1);
    write_length(length);

    for (int e = 0; e < entries; e++) begin
      if (e > 0) begin
        drain();
        write_length(length);
      end
      send_header(types[e], styles[e], sizes[e], END_OK);
      for (int i = 0; i < padded(sizes[e]); i++) send_byte(8'($urandom));
    end

    case (finish_kind)
      END_TRUNC:    send_header("0", SZ_DEC, 64'd999999999999, END_OK);
      END_OVERFLOW: send_header("0", SZ_OCT, 64'h1FFFFFFFF, END_OK);
      END_MAGIC, END_VERSION, END_NONDIGIT:
        send_header("0", SZ_OCT, $urandom_range(0, 20), finish_kind);
      default: ;
    endcase
    // Bytes after the archive has ended are dropped by the block.
    for (int i = 0; i < 30; i++) send_byte(8'($urandom));

    drain();
    repeat (50) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ustar_archive_stream_reader_test OK");
    end else begin
      $display("ustar_archive_stream_reader_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("ustar_archive_stream_reader_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/uasr_pkg.sv
rtl/core/uasr_front.sv
rtl/core/uasr_queue.sv
rtl/core/uasr_back.sv
rtl/core/ustar_archive_stream_reader.sv
verif/ustar_archive_stream_reader_test.sv
